/* src/name_score_table_core_assert.svh */
// Assertion macros shared by the name score table RTL.
`ifndef NAME_SCORE_TABLE_CORE_ASSERT_SVH
`define NAME_SCORE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/nst_pkg.sv */
// Types and constants of the name score table.
`timescale 1ns / 1ps
`default_nettype none

package nst_pkg;

  localparam int unsigned NAME_W  = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EXISTS = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESULT
  } state_e;

  // A name after length clamping and masking of the bytes past its length.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [NAME_W-1:0] name;
  } key_t;

endpackage

`default_nettype wire

/* src/nst_if.sv */
// Request and response channel interfaces of the name score table.
`timescale 1ns / 1ps
`default_nettype none

interface nst_req_if;
  logic                                valid;
  logic                                ready;
  logic [nst_pkg::OP_W-1:0]            operation;
  logic [nst_pkg::NAME_W-1:0]          name_bytes;
  logic [nst_pkg::LEN_W-1:0]           name_length;
  logic signed [nst_pkg::SCORE_W-1:0]  new_score;

  modport source (output valid, operation, name_bytes, name_length, new_score,
                  input ready);
  modport sink   (input valid, operation, name_bytes, name_length, new_score,
                  output ready);
endinterface

interface nst_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [nst_pkg::SCORE_W-1:0]  score_out;
  logic [nst_pkg::COUNT_W-1:0]         entry_count;
  logic [nst_pkg::STAT_W-1:0]          status;

  modport source (output valid, found, score_out, entry_count, status,
                  input ready);
  modport sink   (input valid, found, score_out, entry_count, status,
                  output ready);
endinterface

`default_nettype wire

/* src/name_score_table_core.sv */
// Top level of the name score table: sequencer, entry memory and result register.
// Sequence: accept, then compare entries one by one until the first match (at most the entry
// count), then for a delete move each later entry one place down, then load the result.
// Items: one item at a time; the search and shift steps are bounded by the single read port of
// the entry memory, and the next item is accepted only once the result has been loaded.
// Reset: rst_ni clears the entry count, the sequencer and the result valid; memory contents stay
// undefined and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none
`include "name_score_table_core_assert.svh"

module name_score_table_core #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned NAME_CHARS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nst_req_if.sink    req_i,
  nst_rsp_if.source  rsp_o
);
  import nst_pkg::*;

  // Widths that follow from the parameters. The count needs one more code than the index
  // because a full table holds CAPACITY entries.
  localparam int unsigned IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned LW  = $clog2(NAME_CHARS + 1);
  localparam int unsigned NW  = 8 * NAME_CHARS;
  localparam int unsigned EW  = LW + NW + SCORE_W;
  localparam int unsigned CXW = CW + COUNT_W;

  // Sequencer and request registers.
  state_e                     state_q, state_d;
  op_e                        op_q, op_d;
  logic [LW-1:0]              len_q, len_d;
  logic [NW-1:0]              name_q, name_d;
  logic signed [SCORE_W-1:0]  score_in_q, score_in_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              scan_q, scan_d;
  logic                       hit_q, hit_d;
  logic signed [SCORE_W-1:0]  hit_score_q, hit_score_d;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  logic                       out_found_q;
  logic signed [SCORE_W-1:0]  out_score_q;
  logic [COUNT_W-1:0]         out_count_q;
  status_e                    out_status_q;

  // Entry memory: {length, name, score} per entry, one write and one registered read a cycle.
  logic [EW-1:0]              mem [CAPACITY];
  logic [EW-1:0]              rdata_q;
  logic [CW-1:0]              rd_addr;
  logic [CW-1:0]              wr_addr;
  logic                       mem_we;
  logic [EW-1:0]              wr_data;

  key_t                       key_c;
  logic                       req_fire;
  logic                       out_free;
  logic                       out_load;
  logic                       entry_match;
  logic [CW-1:0]              scan_nxt;
  logic [LW-1:0]              ent_len;
  logic [NW-1:0]              ent_name;
  logic signed [SCORE_W-1:0]  ent_score;
  status_e                    status_d;
  logic [CXW-1:0]             count_ext;

  nst_key_fmt #(
    .NAME_CHARS (NAME_CHARS)
  ) u_key_fmt (
    .name_i (req_i.name_bytes),
    .len_i  (req_i.name_length),
    .key_o  (key_c)
  );

  // The table takes a new item only when the sequencer is idle. The result register lets the
  // next item start while the previous result still waits downstream.
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = (state_q == S_RESULT) && out_free;

  assign {ent_len, ent_name, ent_score} = rdata_q;
  assign entry_match = (ent_len == len_q) && (ent_name == name_q);
  assign scan_nxt    = scan_q + 1'b1;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = (count_q == '0) ? S_RESULT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (entry_match) begin
          state_d = (op_q == OP_DELETE && scan_nxt < count_q) ? S_SHIFT : S_RESULT;
        end else if (scan_nxt == count_q) begin
          state_d = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (scan_nxt >= count_q) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control: memory accesses, request capture, search results and the final status.
  always_comb begin
    op_d        = op_q;
    len_d       = len_q;
    name_d      = name_q;
    score_in_d  = score_in_q;
    count_d     = count_q;
    scan_d      = scan_q;
    hit_d       = hit_q;
    hit_score_d = hit_score_q;
    rd_addr     = '0;
    wr_addr     = '0;
    mem_we      = 1'b0;
    wr_data     = {len_q, name_q, score_in_q};
    status_d    = ST_DONE;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d        = op_e'(req_i.operation);
          len_d       = key_c.len[LW-1:0];
          name_d      = key_c.name[NW-1:0];
          score_in_d  = req_i.new_score;
          scan_d      = '0;
          hit_d       = 1'b0;
          hit_score_d = '0;
        end
      end
      S_SEARCH: begin
        // rdata_q holds the entry at scan_q; the next entry is fetched in the same cycle.
        if (entry_match) begin
          hit_d       = 1'b1;
          hit_score_d = ent_score;
          if (op_q == OP_DELETE && scan_nxt < count_q) begin
            scan_d  = scan_nxt;
            rd_addr = scan_nxt;
          end
        end else if (scan_nxt != count_q) begin
          scan_d  = scan_nxt;
          rd_addr = scan_nxt;
        end
      end
      S_SHIFT: begin
        // Move the entry at scan_q one place down while the one above it is read. When a read is
        // made, its address is two above the write address, so no forwarding is needed.
        mem_we  = 1'b1;
        wr_addr = scan_q - 1'b1;
        wr_data = rdata_q;
        if (scan_nxt < count_q) begin
          scan_d  = scan_nxt;
          rd_addr = scan_nxt;
        end
      end
      S_RESULT: begin
        case (op_q)
          OP_INSERT: begin
            if (hit_q) begin
              status_d = ST_EXISTS;
            end else if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_DONE;
              if (out_free) begin
                mem_we  = 1'b1;
                wr_addr = count_q;
                count_d = count_q + 1'b1;
              end
            end
          end
          OP_DELETE: begin
            status_d = hit_q ? ST_DONE : ST_ABSENT;
            if (hit_q && out_free) begin
              count_d = count_q - 1'b1;
            end
          end
          default: begin
            // Lookup, and the unused operation code, which behaves as a lookup.
            status_d = hit_q ? ST_DONE : ST_ABSENT;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign count_ext = CXW'(count_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    len_q       <= len_d;
    name_q      <= name_d;
    score_in_q  <= score_in_d;
    scan_q      <= scan_d;
    hit_q       <= hit_d;
    hit_score_q <= hit_score_d;
    if (out_load) begin
      out_found_q  <= hit_q;
      out_score_q  <= hit_score_q;
      out_count_q  <= count_ext[COUNT_W-1:0];
      out_status_q <= status_d;
    end
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr[IW-1:0]] <= wr_data;
    end
    rdata_q <= mem[rd_addr[IW-1:0]];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.score_out   = out_score_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.status      = out_status_q;

  // The entry count never passes the table size.
  `NST_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "entry count above capacity")
  // An accepted item always leaves the idle state for the search or the result.
  `NST_ASSERT_NXT(a_accept_leaves_idle, req_fire, state_q != S_IDLE, "item accepted but idle")
  // Entries are moved only for a delete that found its name.
  `NST_ASSERT_IMP(a_shift_on_delete_hit, state_q == S_SHIFT,
                  hit_q && op_q == OP_DELETE, "shift without a delete hit")
  // A successful insert grows the table by exactly one entry.
  `NST_ASSERT_NXT(a_insert_grows, out_load && op_q == OP_INSERT && status_d == ST_DONE,
                  count_q == $past(count_q) + 1'b1, "insert did not add one entry")

endmodule

`default_nettype wire

/* src/nst_key_fmt.sv */
// Key formatter: clamps the name length and clears the bytes past it.
`timescale 1ns / 1ps
`default_nettype none

module nst_key_fmt #(
  parameter int unsigned NAME_CHARS = 8
) (
  input  wire logic [nst_pkg::NAME_W-1:0] name_i,
  input  wire logic [nst_pkg::LEN_W-1:0]  len_i,
  output nst_pkg::key_t                   key_o
);
  import nst_pkg::*;

  logic [LEN_W-1:0] len_c;

  always_comb begin
    len_c = (len_i > LEN_W'(NAME_CHARS)) ? LEN_W'(NAME_CHARS) : len_i;
    key_o.len = len_c;
    for (int b = 0; b < NAME_W / 8; b++) begin
      key_o.name[b*8 +: 8] = (LEN_W'(b) < len_c) ? name_i[b*8 +: 8] : 8'h00;
    end
  end

endmodule

`default_nettype wire
